// ===== design/i2cbe_pkg.sv =====
// Package: command codes, transfer payload types and phase limits for the I2C bit engine.
package i2cbe_pkg;

  typedef enum logic [2:0] {
    FUNC_START   = 3'd0,
    FUNC_STOP    = 3'd1,
    FUNC_WRITE   = 3'd2,
    FUNC_READ    = 3'd3,
    FUNC_SENDACK = 3'd4,
    FUNC_RECVACK = 3'd5
  } func_e;

  localparam int unsigned PhaseW = 5;
  localparam logic [7:0] MsbMask = 8'h80;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] func;
    logic [7:0] tx_byte;
    logic       ack_out;
    logic       sda_in;
  } cmd_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       cmd_done;
    logic [7:0] rx_byte;
    logic       ack_in;
  } res_t;

  function automatic logic [PhaseW-1:0] last_phase(func_e cmd);
    logic [PhaseW-1:0] lp;
    case (cmd)
      FUNC_START:   lp = 5'd3;
      FUNC_STOP:    lp = 5'd2;
      FUNC_WRITE:   lp = 5'd23;
      FUNC_READ:    lp = 5'd24;
      FUNC_SENDACK: lp = 5'd2;
      default:      lp = 5'd3;
    endcase
    return lp;
  endfunction

endpackage

// ===== design/i2cbe_if.sv =====
// Interfaces: tick command channel and pin result channel.
interface i2cbe_cmd_if;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic [2:0] func;
  logic [7:0] tx_byte;
  logic       ack_out;
  logic       sda_in;

  modport source (output valid, cmd_valid, func, tx_byte, ack_out, sda_in, input ready);
  modport sink   (input valid, cmd_valid, func, tx_byte, ack_out, sda_in, output ready);
endinterface

interface i2cbe_res_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       cmd_done;
  logic [7:0] rx_byte;
  logic       ack_in;

  modport source (output valid, scl_out, sda_out, busy_res, cmd_done, rx_byte, ack_in,
                  input ready);
  modport sink   (input valid, scl_out, sda_out, busy_res, cmd_done, rx_byte, ack_in,
                  output ready);
endinterface

// ===== design/i2cbe_in_reg.sv =====
// Input register: captures one tick item from the command channel.
module i2cbe_in_reg
  import i2cbe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  i2cbe_cmd_if.sink   cmd_i,
  input  logic        adv_i,
  output logic        valid_o,
  output cmd_t        item_o
);

  logic valid_q, valid_d;
  cmd_t item_q, item_d;
  logic take;

  assign cmd_i.ready = !valid_q || adv_i;
  assign take        = cmd_i.valid && cmd_i.ready;

  always_comb begin
    valid_d = take ? 1'b1 : (adv_i ? 1'b0 : valid_q);
    item_d  = item_q;
    if (take) begin
      item_d.cmd_valid = cmd_i.cmd_valid;
      item_d.func      = cmd_i.func;
      item_d.tx_byte   = cmd_i.tx_byte;
      item_d.ack_out   = cmd_i.ack_out;
      item_d.sda_in    = cmd_i.sda_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== design/i2cbe_core.sv =====
// Phase engine: bus state registers and the per-tick pin phase logic.
module i2cbe_core
  import i2cbe_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic adv_i,
  input  cmd_t item_i,
  output res_t res_o
);

  logic              scl_q, scl_d;
  logic              sda_q, sda_d;
  logic              active_q, active_d;
  func_e             cmd_q, cmd_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [1:0]        sub_q, sub_d;
  logic [7:0]        shift_q, shift_d;
  logic [7:0]        rx_q, rx_d;
  logic              rack_q, rack_d;

  logic              start;
  logic              act;
  func_e             cmd;
  logic [PhaseW-1:0] p;
  logic [1:0]        sub;
  logic [7:0]        shift;
  logic              done;
  logic [1:0]        sub_inc;

  always_comb begin
    start = !active_q && item_i.cmd_valid && (item_i.func <= 3'(FUNC_RECVACK));
    act   = start || active_q;
    cmd   = start ? func_e'(item_i.func) : cmd_q;
    p     = start ? '0 : phase_q;
    sub   = start ? 2'd0 : sub_q;
    shift = shift_q;
    if (start && cmd == FUNC_WRITE) begin
      shift = item_i.tx_byte;
    end else if (start && cmd == FUNC_READ) begin
      shift = '0;
    end
    sub_inc = (sub == 2'd2) ? 2'd0 : sub + 2'd1;

    scl_d    = scl_q;
    sda_d    = sda_q;
    shift_d  = shift;
    rack_d   = rack_q;
    rx_d     = rx_q;
    active_d = act;
    cmd_d    = cmd;
    phase_d  = p;
    sub_d    = sub_inc;
    done     = 1'b0;

    if (act) begin
      case (cmd)
        FUNC_START: begin
          case (p[1:0])
            2'd0:    sda_d = 1'b1;
            2'd1:    scl_d = 1'b1;
            2'd2:    sda_d = 1'b0;
            default: scl_d = 1'b0;
          endcase
        end
        FUNC_STOP: begin
          case (p[1:0])
            2'd0:    sda_d = 1'b0;
            2'd1:    scl_d = 1'b1;
            default: sda_d = 1'b1;
          endcase
        end
        FUNC_WRITE: begin
          case (sub)
            2'd0:    sda_d = |(shift & MsbMask);
            2'd1:    scl_d = 1'b1;
            default: begin
              scl_d   = 1'b0;
              shift_d = {shift[6:0], 1'b0};
            end
          endcase
        end
        FUNC_READ: begin
          if (p == '0) begin
            sda_d = 1'b1;
            sub_d = 2'd0;
          end else begin
            case (sub)
              2'd0:    scl_d = 1'b1;
              2'd1:    shift_d = {shift[6:0], item_i.sda_in};
              default: scl_d = 1'b0;
            endcase
          end
        end
        FUNC_SENDACK: begin
          case (p[1:0])
            2'd0:    sda_d = item_i.ack_out;
            2'd1:    scl_d = 1'b1;
            default: scl_d = 1'b0;
          endcase
        end
        default: begin
          case (p[1:0])
            2'd0:    sda_d = 1'b1;
            2'd1:    scl_d = 1'b1;
            2'd2:    rack_d = item_i.sda_in;
            default: scl_d = 1'b0;
          endcase
        end
      endcase

      if (p >= last_phase(cmd)) begin
        if (cmd == FUNC_READ) begin
          rx_d = shift_d;
        end
        active_d = 1'b0;
        phase_d  = '0;
        sub_d    = 2'd0;
        done     = 1'b1;
      end else begin
        phase_d = p + 5'd1;
      end
    end else begin
      sub_d = sub_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scl_q    <= 1'b1;
      sda_q    <= 1'b1;
      active_q <= 1'b0;
      cmd_q    <= FUNC_START;
      phase_q  <= '0;
      sub_q    <= 2'd0;
      shift_q  <= '0;
      rx_q     <= '0;
      rack_q   <= 1'b0;
    end else if (adv_i) begin
      scl_q    <= scl_d;
      sda_q    <= sda_d;
      active_q <= active_d;
      cmd_q    <= cmd_d;
      phase_q  <= phase_d;
      sub_q    <= sub_d;
      shift_q  <= shift_d;
      rx_q     <= rx_d;
      rack_q   <= rack_d;
    end
  end

  always_comb begin
    res_o.scl_out  = scl_d;
    res_o.sda_out  = sda_d;
    res_o.busy_res = active_d;
    res_o.cmd_done = done;
    res_o.rx_byte  = rx_d;
    res_o.ack_in   = rack_d;
  end

endmodule

// ===== design/i2cbe_out_reg.sv =====
// Output register: holds one pin result until the result channel takes it.
module i2cbe_out_reg
  import i2cbe_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  res_t         res_i,
  output logic         free_o,
  i2cbe_res_if.source  res_o
);

  logic valid_q, valid_d;
  res_t res_q;

  assign free_o  = !valid_q || res_o.ready;
  assign valid_d = load_i ? 1'b1 : (res_o.ready ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign res_o.valid    = valid_q;
  assign res_o.scl_out  = res_q.scl_out;
  assign res_o.sda_out  = res_q.sda_out;
  assign res_o.busy_res = res_q.busy_res;
  assign res_o.cmd_done = res_q.cmd_done;
  assign res_o.rx_byte  = res_q.rx_byte;
  assign res_o.ack_in   = res_q.ack_in;

endmodule

// ===== design/i2c_master_bit_engine_top.sv =====
// Top level: I2C master bit engine, one pin phase per tick item.
// Path: an accepted tick is held in the input register; its result is then registered in the output register.
// Throughput: one tick per cycle unless output stalls; the phase update is a single pass
// from the input register through the phase engine into the output register.
// Reset: asynchronous, active low; SCL and SDA released, engine idle, both channels empty.
module i2c_master_bit_engine_top
  import i2cbe_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  i2cbe_cmd_if.sink    cmd_i,
  i2cbe_res_if.source  res_o
);

  logic s1_valid;
  cmd_t s1_item;
  logic out_free;
  logic adv;
  res_t res_next;

  assign adv = s1_valid && out_free;

  i2cbe_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_i),
    .adv_i   (adv),
    .valid_o (s1_valid),
    .item_o  (s1_item)
  );

  i2cbe_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (s1_item),
    .res_o  (res_next)
  );

  i2cbe_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (adv),
    .res_i  (res_next),
    .free_o (out_free),
    .res_o  (res_o)
  );

endmodule

// ===== design/i2cbe_checker.sv =====
// Checker: port-level assertions for the I2C bit engine, bound to the top level.
module i2cbe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cmd_ready_i,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic       busy_i,
  input logic       done_i,
  input logic       scl_i,
  input logic       sda_i,
  input logic [7:0] rx_i
);

  ast_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(scl_i) && $stable(sda_i)
      && $stable(rx_i))
    else $error("result changed while stalled");

  ast_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && done_i |-> !busy_i)
    else $error("finished command still reported busy");

  ast_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_ready_i |-> res_valid_i && !res_ready_i)
    else $error("input stalled without an output stall");

endmodule

bind i2c_master_bit_engine_top i2cbe_checker u_i2cbe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cmd_ready_i (cmd_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .busy_i      (res_o.busy_res),
  .done_i      (res_o.cmd_done),
  .scl_i       (res_o.scl_out),
  .sda_i       (res_o.sda_out),
  .rx_i        (res_o.rx_byte)
);
